// ===== hw/rtl/trs_model_matrix_builder_core_macros.svh =====
// Assertion macros for the TRS model matrix builder.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TRS_MODEL_MATRIX_BUILDER_CORE_MACROS_SVH
`define TRS_MODEL_MATRIX_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TMMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TMMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tmmb_pkg.sv =====
// Shared types, widths and helpers for the TRS model matrix builder.
// No dependencies; used by every module of the block.
package tmmb_pkg;

  localparam int unsigned NLANE = 3;
  localparam int unsigned RFRAC = 30;
  localparam int unsigned QUOTW = 32;
  localparam int unsigned DENW  = 33;
  localparam int unsigned NUMW  = 34;
  localparam int unsigned DIVW  = 64;
  localparam int unsigned RW    = 33;
  localparam int unsigned MPW   = 65;
  localparam int unsigned MW    = 35;
  localparam int unsigned PPW   = 67;
  localparam int unsigned SUMW  = 69;

  localparam logic [1:0] ROW_X    = 2'd0;
  localparam logic [1:0] ROW_Y    = 2'd1;
  localparam logic [1:0] ROW_Z    = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  localparam logic signed [RW-1:0]  R_ONE   = RW'(1) << RFRAC;
  localparam logic signed [MPW-1:0] MP_HALF = MPW'(1) << (RFRAC - 1);
  localparam logic [31:0]           SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0]           SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [NLANE-1:0][31:0] pos;
    logic [NLANE-1:0][31:0] scale;
    logic [15:0]            qw;
    logic [15:0]            qx;
    logic [15:0]            qy;
    logic [15:0]            qz;
  } item_t;

  typedef struct packed {
    logic [1:0]             row;
    logic                   zero;
    logic [NLANE-1:0]       neg;
    logic [NLANE-1:0][31:0] scale;
    logic [NLANE-1:0][31:0] pos;
  } side_t;

  // Clamp to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [SUMW-1:0] v);
    logic hi_zero;
    logic hi_ones;
    hi_zero = (v[SUMW-1:31] == '0);
    hi_ones = (v[SUMW-1:31] == '1);
    if (hi_zero || hi_ones) begin
      return v[31:0];
    end
    return v[SUMW-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

// ===== hw/rtl/tmmb_front.sv =====
// Front end: holds one item, issues its four rows, forms the squared norm
// and the rotation numerators and the dividends. Depends on tmmb_pkg.
module tmmb_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   adv_i,
  input  logic                                   in_valid_i,
  input  tmmb_pkg::item_t                        item_i,
  output logic                                   in_ready_o,
  output logic                                   valid_o,
  output logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::DIVW-1:0] dividend_o,
  output logic [tmmb_pkg::DENW-1:0]              den_o,
  output tmmb_pkg::side_t                        side_o
);

  tmmb_pkg::item_t itm_q;
  logic [1:0]      cnt_q;
  logic            act_q;
  logic            v1_q, v2_q, v3_q;
  logic            accept;
  logic            issue;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  tmmb_pkg::side_t    s1_q, s2_q, s3_d, s3_q;

  logic [tmmb_pkg::DENW-1:0]                         n2_q, den_q;
  logic signed [tmmb_pkg::NLANE-1:0][tmmb_pkg::NUMW-1:0] num_d, num_q;
  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::DIVW-1:0]    dvd_d, dvd_q;
  logic [tmmb_pkg::NLANE-1:0]                        neg_d;

  function automatic logic [tmmb_pkg::NUMW-1:0] dbl(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic sub);
    logic signed [32:0] s;
    s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
    return {s, 1'b0};
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign issue      = act_q && adv_i;
  assign in_ready_o = !act_q || (adv_i && (cnt_q == tmmb_pkg::ROW_LAST));

  assign qw = $signed(itm_q.qw);
  assign qx = $signed(itm_q.qx);
  assign qy = $signed(itm_q.qy);
  assign qz = $signed(itm_q.qz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= tmmb_pkg::ROW_X;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (accept) begin
        act_q <= 1'b1;
        cnt_q <= tmmb_pkg::ROW_X;
      end else if (issue) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == tmmb_pkg::ROW_LAST) begin
          act_q <= 1'b0;
        end
      end
      if (adv_i) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  // Numerators of the three elements of this row; the diagonal lane is 2*(b^2+c^2).
  always_comb begin
    num_d = '0;
    case (s1_q.row)
      tmmb_pkg::ROW_X: begin
        num_d[0] = dbl(yy_q, zz_q, 1'b0);
        num_d[1] = dbl(xy_q, wz_q, 1'b1);
        num_d[2] = dbl(xz_q, wy_q, 1'b0);
      end
      tmmb_pkg::ROW_Y: begin
        num_d[0] = dbl(xy_q, wz_q, 1'b0);
        num_d[1] = dbl(xx_q, zz_q, 1'b0);
        num_d[2] = dbl(yz_q, wx_q, 1'b1);
      end
      tmmb_pkg::ROW_Z: begin
        num_d[0] = dbl(xz_q, wy_q, 1'b1);
        num_d[1] = dbl(yz_q, wx_q, 1'b0);
        num_d[2] = dbl(xx_q, yy_q, 1'b0);
      end
      default: begin
        num_d = '0;
      end
    endcase
  end

  // Dividend = |num| * 2^30 + den/2 for round-to-nearest division.
  always_comb begin
    for (int j = 0; j < tmmb_pkg::NLANE; j++) begin
      neg_d[j] = num_q[j][tmmb_pkg::NUMW-1];
      dvd_d[j] = {(neg_d[j] ? (-num_q[j]) : num_q[j]), 30'b0}
               + {32'b0, n2_q[tmmb_pkg::DENW-1:1]};
    end
  end

  // Side data of the third stage: flag a zero norm, keep the numerator signs.
  always_comb begin
    s3_d      = s2_q;
    s3_d.zero = (n2_q == '0);
    s3_d.neg  = neg_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      itm_q <= item_i;
    end
    if (adv_i) begin
      ww_q <= qw * qw;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      xy_q <= qx * qy;
      xz_q <= qx * qz;
      yz_q <= qy * qz;
      wx_q <= qw * qx;
      wy_q <= qw * qy;
      wz_q <= qw * qz;
      s1_q.row   <= cnt_q;
      s1_q.zero  <= 1'b0;
      s1_q.neg   <= '0;
      s1_q.scale <= itm_q.scale;
      s1_q.pos   <= itm_q.pos;

      n2_q  <= 33'(ww_q) + 33'(xx_q) + 33'(yy_q) + 33'(zz_q);
      num_q <= num_d;
      s2_q  <= s1_q;

      den_q <= n2_q;
      dvd_q <= dvd_d;
      s3_q  <= s3_d;
    end
  end

  assign valid_o    = v3_q;
  assign dividend_o = dvd_q;
  assign den_o      = den_q;
  assign side_o     = s3_q;

endmodule

// ===== hw/rtl/tmmb_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage. Depends on tmmb_pkg.
module tmmb_div (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            adv_i,
  input  logic                                            valid_i,
  input  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::DIVW-1:0]  dividend_i,
  input  logic [tmmb_pkg::DENW-1:0]                       den_i,
  input  tmmb_pkg::side_t                                 side_i,
  output logic                                            valid_o,
  output logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::QUOTW-1:0] quot_o,
  output tmmb_pkg::side_t                                 side_o
);

  localparam int unsigned STAGES = tmmb_pkg::QUOTW;

  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::DENW-1:0]  rem_q [STAGES];
  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::QUOTW-1:0] lo_q  [STAGES];
  logic [tmmb_pkg::DENW-1:0]                       den_q [STAGES];
  tmmb_pkg::side_t                                 side_q[STAGES];
  logic                                            vld_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stg
    logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::DENW-1:0]  rp, rn;
    logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::QUOTW-1:0] lp, ln;
    logic [tmmb_pkg::DENW-1:0]                       dp;
    tmmb_pkg::side_t                                 sp;
    logic                                            vp;

    if (k == 0) begin : g_head
      always_comb begin
        for (int j = 0; j < tmmb_pkg::NLANE; j++) begin
          rp[j] = {1'b0, dividend_i[j][tmmb_pkg::DIVW-1:tmmb_pkg::QUOTW]};
          lp[j] = dividend_i[j][tmmb_pkg::QUOTW-1:0];
        end
      end
      assign dp = den_i;
      assign sp = side_i;
      assign vp = valid_i;
    end else begin : g_body
      assign rp = rem_q[k-1];
      assign lp = lo_q[k-1];
      assign dp = den_q[k-1];
      assign sp = side_q[k-1];
      assign vp = vld_q[k-1];
    end

    // Shift in the next dividend bit, subtract if it fits, record the bit.
    always_comb begin
      logic [tmmb_pkg::DENW:0] t;
      logic                    ge;
      for (int j = 0; j < tmmb_pkg::NLANE; j++) begin
        t     = {rp[j], lp[j][tmmb_pkg::QUOTW-1]};
        ge    = (t >= {1'b0, dp});
        rn[j] = ge ? tmmb_pkg::DENW'(t - {1'b0, dp}) : tmmb_pkg::DENW'(t);
        ln[j] = {lp[j][tmmb_pkg::QUOTW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rn;
        lo_q[k]   <= ln;
        den_q[k]  <= dp;
        side_q[k] <= sp;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign quot_o  = lo_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

// ===== hw/rtl/tmmb_back.sv =====
// Back end: rotation elements, scale and translation products, rounding,
// saturation and the output register. Depends on tmmb_pkg.
module tmmb_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            adv_i,
  input  logic                                            valid_i,
  input  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::QUOTW-1:0] quot_i,
  input  tmmb_pkg::side_t                                 side_i,
  output logic                                            out_valid_o,
  output logic [1:0]                                      row_index_o,
  output logic [31:0]                                     col0_o,
  output logic [31:0]                                     col1_o,
  output logic [31:0]                                     col2_o,
  output logic [31:0]                                     col3_o,
  output logic                                            last_row_o
);

  localparam logic signed [tmmb_pkg::PPW-1:0] PP_HALF = tmmb_pkg::PPW'(1) << (FRAC_BITS - 1);
  localparam logic [31:0]                     POS_ONE = 32'd1 << FRAC_BITS;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  tmmb_pkg::side_t s1_q, s2_q, s3_q, s4_q, s5_q;

  logic signed [tmmb_pkg::NLANE-1:0][tmmb_pkg::RW-1:0]  r_d, r_q;
  logic signed [tmmb_pkg::NLANE-1:0][tmmb_pkg::MPW-1:0] mp_q;
  logic signed [tmmb_pkg::NLANE-1:0][tmmb_pkg::MW-1:0]  m_d, m_q, m4_q, m5_q;
  logic signed [tmmb_pkg::NLANE-1:0][tmmb_pkg::PPW-1:0] pp_q, rt_d, rt_q;

  logic [1:0]  row_q;
  logic [31:0] c0_q, c1_q, c2_q, c3_q;
  logic        last_q;
  logic signed [tmmb_pkg::SUMW-1:0] t_sum;

  // Rotation element of this row; identity when the norm is zero.
  always_comb begin
    logic signed [tmmb_pkg::RW-1:0] q;
    for (int j = 0; j < tmmb_pkg::NLANE; j++) begin
      q = $signed({1'b0, quot_i[j]});
      if (side_i.zero) begin
        r_d[j] = (side_i.row == 2'(j)) ? tmmb_pkg::R_ONE : '0;
      end else if (side_i.row == 2'(j)) begin
        r_d[j] = tmmb_pkg::R_ONE - q;
      end else begin
        r_d[j] = side_i.neg[j] ? -q : q;
      end
    end
  end

  // Round half away from zero: (v + half - sign) >>> shift.
  always_comb begin
    logic signed [tmmb_pkg::MPW-1:0] rs;
    logic signed [tmmb_pkg::PPW-1:0] ps;
    for (int j = 0; j < tmmb_pkg::NLANE; j++) begin
      rs     = mp_q[j] + tmmb_pkg::MP_HALF
             - $signed({{(tmmb_pkg::MPW-1){1'b0}}, mp_q[j][tmmb_pkg::MPW-1]});
      m_d[j] = tmmb_pkg::MW'(rs >>> tmmb_pkg::RFRAC);
      ps      = pp_q[j] + PP_HALF
              - $signed({{(tmmb_pkg::PPW-1){1'b0}}, pp_q[j][tmmb_pkg::PPW-1]});
      rt_d[j] = ps >>> FRAC_BITS;
    end
  end

  assign t_sum = tmmb_pkg::SUMW'($signed(rt_q[0])) + tmmb_pkg::SUMW'($signed(rt_q[1]))
               + tmmb_pkg::SUMW'($signed(rt_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      v1_q        <= valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q  <= r_d;
      s1_q <= side_i;
      for (int j = 0; j < tmmb_pkg::NLANE; j++) begin
        mp_q[j] <= $signed(r_q[j]) * $signed(s1_q.scale[j]);
        pp_q[j] <= $signed(m_q[j]) * $signed(s3_q.pos[j]);
      end
      s2_q <= s1_q;
      m_q  <= m_d;
      s3_q <= s2_q;
      m4_q <= m_q;
      s4_q <= s3_q;
      rt_q <= rt_d;
      m5_q <= m4_q;
      s5_q <= s4_q;

      row_q  <= s5_q.row;
      last_q <= (s5_q.row == tmmb_pkg::ROW_LAST);
      if (s5_q.row == tmmb_pkg::ROW_LAST) begin
        c0_q <= '0;
        c1_q <= '0;
        c2_q <= '0;
        c3_q <= POS_ONE;
      end else begin
        c0_q <= tmmb_pkg::sat32(tmmb_pkg::SUMW'($signed(m5_q[0])));
        c1_q <= tmmb_pkg::sat32(tmmb_pkg::SUMW'($signed(m5_q[1])));
        c2_q <= tmmb_pkg::sat32(tmmb_pkg::SUMW'($signed(m5_q[2])));
        c3_q <= tmmb_pkg::sat32(t_sum);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_q;
  assign col0_o      = c0_q;
  assign col1_o      = c1_q;
  assign col2_o      = c2_q;
  assign col3_o      = c3_q;
  assign last_row_o  = last_q;

endmodule

// ===== hw/rtl/trs_model_matrix_builder_core.sv =====
// TRS model matrix builder, top level.
// Depends on tmmb_pkg, tmmb_front, tmmb_div, tmmb_back and the macros header.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one object per item:
//   position and per-axis scale in signed fixed point with FRAC_BITS fraction
//   bits, and a rotation quaternion in signed Q2.14 that need not be unit.
//   Output channel (out_valid_o / out_ready_i) returns four items per object,
//   rows 0..3 of the 4x4 model matrix in order; last_row_o marks row 3.
//   The quaternion is normalized inside the division; a zero quaternion gives
//   the identity rotation. Emitted elements saturate to 32 bits.
// Throughput: one row per cycle unless a stall holds the pipeline; the front
//   end issues each held object as four row passes through a single pipeline.
// Pipeline: 3 front stages, 32 divider stages with one quotient bit each,
//   5 back stages and the output register.
// Reset: clears all valid bits and the row sequencer; no item is in flight.
// Stall: when out_ready_i is low with a row waiting, the whole pipeline
//   holds; no row is lost or repeated, and input is taken again once the
//   current object's last row has been issued.
`include "trs_model_matrix_builder_core_macros.svh"

module trs_model_matrix_builder_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic               last_row_o
);

  logic            adv;
  tmmb_pkg::item_t item;

  logic                                                   f_valid;
  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::DIVW-1:0]         f_dividend;
  logic [tmmb_pkg::DENW-1:0]                              f_den;
  tmmb_pkg::side_t                                        f_side;

  logic                                                   d_valid;
  logic [tmmb_pkg::NLANE-1:0][tmmb_pkg::QUOTW-1:0]        d_quot;
  tmmb_pkg::side_t                                        d_side;

  logic [31:0] c0, c1, c2, c3;

  // Advance every stage unless a finished row is waiting at the output.
  assign adv = !out_valid_o || out_ready_i;

  assign item.pos   = {pos_z_i, pos_y_i, pos_x_i};
  assign item.scale = {scale_z_i, scale_y_i, scale_x_i};
  assign item.qw    = quat_w_i;
  assign item.qx    = quat_x_i;
  assign item.qy    = quat_y_i;
  assign item.qz    = quat_z_i;

  tmmb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .item_i     (item),
    .in_ready_o (in_ready_o),
    .valid_o    (f_valid),
    .dividend_o (f_dividend),
    .den_o      (f_den),
    .side_o     (f_side)
  );

  tmmb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (f_valid),
    .dividend_i (f_dividend),
    .den_i      (f_den),
    .side_i     (f_side),
    .valid_o    (d_valid),
    .quot_o     (d_quot),
    .side_o     (d_side)
  );

  tmmb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (d_valid),
    .quot_i      (d_quot),
    .side_i      (d_side),
    .out_valid_o (out_valid_o),
    .row_index_o (row_index_o),
    .col0_o      (c0),
    .col1_o      (c1),
    .col2_o      (c2),
    .col3_o      (c3),
    .last_row_o  (last_row_o)
  );

  assign col0_o = $signed(c0);
  assign col1_o = $signed(c1);
  assign col2_o = $signed(c2);
  assign col3_o = $signed(c3);

  // A newly taken object blocks input until its last row is issued.
  `TMMB_ASSERT_NXT(a_in_block, in_valid_i && in_ready_o, !in_ready_o, "input taken while rows pending")
  // Rows of one object leave back to back once a row is taken.
  `TMMB_ASSERT_NXT(a_row_follow, out_valid_o && out_ready_i && !last_row_o, out_valid_o, "gap between rows of one object")
  `TMMB_ASSERT_NXT(a_row_incr, out_valid_o && out_ready_i && !last_row_o, row_index_o == $past(row_index_o) + 2'd1, "row index out of order")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for trs_model_matrix_builder_core.
// Depends on tmmb_pkg (row codes) and the block's RTL; predicts every matrix row.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // One object as offered on the input channel.
  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [31:0] sx, sy, sz;
    logic signed [15:0] qw, qx, qy, qz;
  } object_t;

  // One matrix row as returned on the output channel.
  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] c0, c1, c2, c3;
    logic               last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] scale_x_i = '0, scale_y_i = '0, scale_z_i = '0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] row_index_o;
  logic signed [31:0] col0_o, col1_o, col2_o, col3_o;
  logic last_row_o;

  object_t pending_objects[$];
  row_t    expected_rows[$];
  int      fail_count = 0;
  int      objects_sent = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 14;
  int      recv_idle_pct = 88;
  int      holdoff_left = 0;
  bit      stim_done = 1'b0;

  always #1 clk_i = ~clk_i;

  trs_model_matrix_builder_core #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

  // Round v / 2^sh to nearest, ties away from zero.
  function automatic longint shift_round(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // round(num * 2^30 / den), ties away from zero.
  function automatic longint norm_ratio(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << 30) + (den >>> 1)) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round(a*b / 2^FRAC_BITS) computed in 128 bits.
  function automatic longint wide_round(longint a, longint b);
    logic signed [127:0] prod;
    logic signed [127:0] half;
    half = 128'sd1 <<< (FRAC_BITS - 1);
    prod = 128'(a) * 128'(b);
    if (prod >= 0) return longint'((prod + half) >>> FRAC_BITS);
    return -longint'((-prod + half) >>> FRAC_BITS);
  endfunction

  // Queue one expected row behind the others.
  function automatic void expect_row(row_t rr);
    expected_rows = {expected_rows, rr};
  endfunction

  // Queue one object for the driver.
  function automatic void add_object(object_t o);
    pending_objects = {pending_objects, o};
  endfunction

  // Build the four rows of the model matrix and queue them.
  task automatic predict_rows(object_t o);
    longint p[3], s[3], r[3][3], m[3][3];
    longint w, x, y, z, n2, one, t;
    row_t rr;
    p[0] = o.px; p[1] = o.py; p[2] = o.pz;
    s[0] = o.sx; s[1] = o.sy; s[2] = o.sz;
    w = o.qw; x = o.qx; y = o.qy; z = o.qz;
    n2 = w*w + x*x + y*y + z*z;
    one = longint'(1) << 30;
    if (n2 == 0) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) r[i][j] = (i == j) ? one : 0;
    end else begin
      r[0][0] = one - norm_ratio(2*(y*y + z*z), n2);
      r[0][1] = norm_ratio(2*(x*y - w*z), n2);
      r[0][2] = norm_ratio(2*(x*z + w*y), n2);
      r[1][0] = norm_ratio(2*(x*y + w*z), n2);
      r[1][1] = one - norm_ratio(2*(x*x + z*z), n2);
      r[1][2] = norm_ratio(2*(y*z - w*x), n2);
      r[2][0] = norm_ratio(2*(x*z - w*y), n2);
      r[2][1] = norm_ratio(2*(y*z + w*x), n2);
      r[2][2] = one - norm_ratio(2*(x*x + y*y), n2);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = shift_round(r[i][j] * s[j], 30);
    for (int i = 0; i < 3; i++) begin
      t = 0;
      // M*pos terms stay within 2^62; the wide form keeps them exact with margin.
      for (int j = 0; j < 3; j++) t += wide_round(m[i][j], p[j]);
      rr.row = 2'(i);
      rr.c0 = clamp32(m[i][0]);
      rr.c1 = clamp32(m[i][1]);
      rr.c2 = clamp32(m[i][2]);
      rr.c3 = clamp32(t);
      rr.last = 1'b0;
      expect_row(rr);
    end
    rr.row = tmmb_pkg::ROW_LAST;
    rr.c0 = '0; rr.c1 = '0; rr.c2 = '0;
    rr.c3 = clamp32(longint'(1) << FRAC_BITS);
    rr.last = 1'b1;
    expect_row(rr);
  endtask

  function automatic object_t random_object();
    object_t o;
    o = object_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom});
    case ($urandom_range(0, 3))
      0: begin
        // modest poses: small positions and scales, quaternion parts within +-1.0
        o.px = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        o.py = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        o.pz = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        o.sx = $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
        o.sy = $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
        o.sz = $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
        o.qw = $signed(16'($urandom_range(0, 16'h7fff))) - 16'sh4000;
        o.qx = $signed(16'($urandom_range(0, 16'h7fff))) - 16'sh4000;
        o.qy = $signed(16'($urandom_range(0, 16'h7fff))) - 16'sh4000;
        o.qz = $signed(16'($urandom_range(0, 16'h7fff))) - 16'sh4000;
      end
      1: begin
        // tiny quaternion: normalization on near-zero norms
        o.qw = $signed(16'($urandom_range(0, 4))) - 16'sd2;
        o.qx = $signed(16'($urandom_range(0, 4))) - 16'sd2;
        o.qy = $signed(16'($urandom_range(0, 4))) - 16'sd2;
        o.qz = $signed(16'($urandom_range(0, 4))) - 16'sd2;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic object_t make_object(logic signed [31:0] pv, logic signed [31:0] sv,
                                          logic signed [15:0] w, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] z);
    object_t o;
    o.px = pv; o.py = -pv; o.pz = pv >>> 1;
    o.sx = sv; o.sy = sv; o.sz = -sv;
    o.qw = w; o.qx = x; o.qy = y; o.qz = z;
    return o;
  endfunction

  // Fill the item queue: directed extremes first, then random objects.
  initial begin
    add_object(make_object(32'sh00010000, 32'sh00010000, 16'sh4000, 16'sd0, 16'sd0, 16'sd0));
    add_object(make_object(32'sh00010000, 32'sh00020000, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    add_object(make_object(32'sh7fffffff, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    add_object(make_object(32'sh80000000, 32'sh80000000, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    add_object(make_object(32'sh80000000, 32'sh7fffffff, 16'sh4000, 16'sd0, 16'sd0, 16'sd0));
    add_object(make_object(32'sh7fffffff, 32'sh80000000, 16'sd0, 16'sh4000, 16'sd0, 16'sd0));
    add_object(make_object(32'sh12345678, 32'sh00018000, 16'sd0, 16'sd0, 16'sh4000, 16'sd0));
    add_object(make_object(32'sh00030000, 32'sh00010000, 16'sd0, 16'sd0, 16'sd0, 16'sh4000));
    add_object(make_object(32'sh7fffffff, 32'sh7fffffff,
                           16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    add_object(make_object(32'sh80000000, 32'sh80000000,
                           16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    add_object(make_object(32'sh00000001, 32'shffffffff, 16'sd1, 16'sd0, 16'sd0, 16'sd0));
    add_object(make_object(32'shffffffff, 32'sh00000001, 16'sd0, 16'sd1, 16'sd1, 16'sd0));
    add_object(make_object(32'sh00050000, 32'sh00020000,
                           16'sh2d41, 16'sd0, 16'sd0, 16'sh2d41));
    add_object(make_object(32'sh7fffffff, 32'sh40000000,
                           16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
    add_object(make_object(32'sd0, 32'sd0, 16'sh1234, 16'sh5678, 16'sh9abc, 16'shdef0));
    for (int k = 0; k < 255; k++) add_object(random_object());
  end

  // Hold reset at the start of simulation, then release it.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: hold each item until accepted, idle at random between items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_rows({pos_x_i, pos_y_i, pos_z_i, scale_x_i, scale_y_i, scale_z_i,
                      quat_w_i, quat_x_i, quat_y_i, quat_z_i});
        objects_sent <= objects_sent + 1;
        // advance the idling phases by progress through the stimulus
        if (objects_sent == 89) begin
          send_idle_pct <= 88;
          recv_idle_pct <= 14;
        end else if (objects_sent == 179) begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_objects.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          object_t o;
          o = pending_objects.pop_front();
          in_valid_i <= 1'b1;
          {pos_x_i, pos_y_i, pos_z_i, scale_x_i, scale_y_i, scale_z_i,
           quat_w_i, quat_x_i, quat_y_i, quat_z_i} <= o;
        end else begin
          in_valid_i <= 1'b0;
          if (pending_objects.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off to fill the pipeline.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (objects_sent == 40 && holdoff_left == 0 && !stim_done) holdoff_left <= 300;
      if (holdoff_left > 0) begin
        holdoff_left <= (holdoff_left == 1) ? -1 : holdoff_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: compare each accepted row with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rows.size() == 0) begin
        $error("row with no expectation: row_index=%0d", row_index_o);
        fail_count++;
      end else begin
        row_t e;
        e = expected_rows.pop_front();
        if (row_index_o !== e.row) begin
          $error("row_index: expected %0d got %0d", e.row, row_index_o); fail_count++;
        end
        if (col0_o !== e.c0) begin
          $error("col0: expected %0d got %0d", e.c0, col0_o); fail_count++;
        end
        if (col1_o !== e.c1) begin
          $error("col1: expected %0d got %0d", e.c1, col1_o); fail_count++;
        end
        if (col2_o !== e.c2) begin
          $error("col2: expected %0d got %0d", e.c2, col2_o); fail_count++;
        end
        if (col3_o !== e.c3) begin
          $error("col3: expected %0d got %0d", e.c3, col3_o); fail_count++;
        end
        if (last_row_o !== e.last) begin
          $error("last_row: expected %0d got %0d", e.last, last_row_o); fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // End of test: drain, wait out the pipeline latency, report.
  initial begin
    wait (rst_ni);
    wait (stim_done && !in_valid_i && expected_rows.size() == 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && expected_rows.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
